// File: hw/rtl/tgb_pkg.sv
// ---------------------------------------------------------------------------
// tgb_pkg: shared types and constants of the text glyph box renderer
// Glyph font table, register indexes and the job record passed from the
// character front end to the box sequencer.
// ---------------------------------------------------------------------------
package tgb_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FG_COLOR    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BG_COLOR    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_SCALE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_OFFSET  = 2'd3;

   // reset values of the configuration registers
   localparam logic [15:0] FG_COLOR_RST    = 16'hFFFF;
   localparam logic [15:0] BG_COLOR_RST    = 16'h0000;
   localparam logic [7:0]  PIXEL_SCALE_RST = 8'd1;
   localparam logic [15:0] ROW_OFFSET_RST  = 16'h0000;

   // glyph geometry
   localparam int GLYPH_COLS = 4;
   localparam int GLYPH_ROWS = 7;
   localparam logic [1:0] LAST_COL = 2'(GLYPH_COLS - 1);
   localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

   localparam logic [31:0] FALLBACK_GLYPH = 32'h552A552A;

   // A to Z, column 0 in the top byte, bit 6 is the top row
   localparam logic [31:0] LETTER_ROM [26] = '{
      32'h3F48483F, 32'h7F494936, 32'h3E414141, 32'h7F41413E, 32'h7F494941,
      32'hFF484840, 32'h3E414547, 32'h7F08087F, 32'h417F4100, 32'h0641417E,
      32'h7F081463, 32'h7F010101, 32'h7F10207F, 32'h7F300C7F, 32'h3E41413E,
      32'h7F484830, 32'h3E414D3E, 32'h7F484C33, 32'h31494946, 32'h407F4040,
      32'h7F01017F, 32'h700C037C, 32'h7F02047F, 32'h730C0C73, 32'h7209097E,
      32'h63454973
   };

   // 0 to 9
   localparam logic [31:0] NUMERAL_ROM [10] = '{
      32'h3E45493E, 32'h01217F01, 32'h33454931, 32'h41494936, 32'h7808087F,
      32'h71494946, 32'h3E494906, 32'h40474870, 32'h36494936, 32'h3048483F
   };

   // one character handed from the front end to the box sequencer
   typedef struct packed {
      logic [31:0] glyph;
      logic [15:0] col;
      logic [15:0] row;
   } glyph_job_type;

   // font lookup, unknown codes get the checker pattern
   function automatic logic [31:0] glyph_lookup(input logic [7:0] code);
      logic [31:0] g;
      logic [7:0]  ofs;
      g   = FALLBACK_GLYPH;
      ofs = 8'd0;
      case (code)
         8'h20:   g = 32'h00000000;
         8'h28:   g = 32'h081C2241;
         8'h29:   g = 32'h41221C08;
         8'h3A:   g = 32'h00666600;
         8'h2E:   g = 32'h00030300;
         8'h2D:   g = 32'h08080808;
         8'h25:   g = 32'h220C3044;
         8'h2F:   g = 32'h020C3040;
         default: begin
            if (code inside {[8'h30:8'h39]}) begin
               ofs = code - 8'h30;
               g   = NUMERAL_ROM[ofs[3:0]];
            end else if (code inside {[8'h41:8'h5A]}) begin
               ofs = code - 8'h41;
               g   = LETTER_ROM[ofs[4:0]];
            end
         end
      endcase
      return g;
   endfunction

endpackage

// File: hw/rtl/tgb_front.sv
// ---------------------------------------------------------------------------
// tgb_front: character front end
// Accepts characters, keeps the text cursor, looks up the glyph and queues
// one job per character for the box sequencer.
// ---------------------------------------------------------------------------
module tgb_front (
   input  logic                   clock,
   input  logic                   reset,
   // character stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // char_code, start_x, start_y
   input  logic                   req_tuser,   // new_string
   // current dot size
   input  logic [7:0]             pixel_scale,
   // job queue write side
   output logic                   push_valid,
   input  logic                   push_ready,
   output tgb_pkg::glyph_job_type push_data
);
   import tgb_pkg::*;

   logic [15:0] cursor_col_ff, cursor_col_in;
   logic [15:0] cursor_row_ff, cursor_row_in;
   logic [15:0] sel_col;
   logic [15:0] sel_row;
   logic [15:0] advance;
   logic        accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & push_ready;

   // new string reloads the cursor before drawing
   assign sel_col = req_tuser ? req_tdata[23:8]  : cursor_col_ff;
   assign sel_row = req_tuser ? req_tdata[39:24] : cursor_row_ff;

   // cursor steps by six dots
   assign advance = {6'd0, pixel_scale, 2'b00} + {7'd0, pixel_scale, 1'b0};

   assign push_valid      = req_tvalid;
   assign push_data.glyph = glyph_lookup(req_tdata[7:0]);
   assign push_data.col   = sel_col;
   assign push_data.row   = sel_row;

   // cursor next value
   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (accept) begin
         cursor_col_in = sel_col + advance;
         cursor_row_in = sel_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

// File: hw/rtl/tgb_queue.sv
// ---------------------------------------------------------------------------
// tgb_queue: job queue
// Small register queue between the front end and the box sequencer.
// ---------------------------------------------------------------------------
module tgb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  tgb_pkg::glyph_job_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output tgb_pkg::glyph_job_type pop_data
);
   import tgb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   glyph_job_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/tgb_back.sv
// ---------------------------------------------------------------------------
// tgb_back: box sequencer
// Walks the 28 dots of a queued glyph column by column, top row first; emits
// one box window command per cycle via an output register unless rsp stalls.
// ---------------------------------------------------------------------------
module tgb_back (
   input  logic                   clock,
   input  logic                   reset,
   // job queue read side
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  tgb_pkg::glyph_job_type pop_data,
   // configuration
   input  logic [15:0]            fg_color,
   input  logic [15:0]            bg_color,
   input  logic [7:0]             pixel_scale,
   input  logic [15:0]            row_offset,
   // box stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata,   // col_start, col_end, row_start,
                                               // row_end, fill_color
   output logic                   rsp_tlast    // last_box
);
   import tgb_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  col_ff, col_in;
   logic [2:0]  row_ff, row_in;
   logic [31:0] glyph_ff, glyph_in;
   logic [15:0] c0_ff, c0_in;
   logic [15:0] y0_ff, y0_in;
   logic [15:0] base_ff, base_in;
   logic        out_valid_ff, out_valid_in;
   logic [79:0] out_data_ff;
   logic        out_last_ff;

   logic        step;
   logic        last_dot;
   logic        load_job;
   logic [15:0] scale16;
   logic [15:0] scale_m1;
   logic [15:0] c1;
   logic [15:0] r0;
   logic [15:0] r1;
   logic [4:0]  bit_idx;
   logic        dot_on;
   logic [79:0] box_data;

   assign scale16  = {8'd0, pixel_scale};
   assign scale_m1 = scale16 - 16'd1;

   // one box leaves the sequencer when the output register frees up
   assign step     = busy_ff & (~out_valid_ff | rsp_tready);
   assign last_dot = (col_ff == LAST_COL) & (row_ff == LAST_ROW);
   assign pop_ready = ~busy_ff | (step & last_dot);
   assign load_job  = pop_valid & pop_ready;

   // dot select: column byte from the top, bit 6 is the top row
   assign bit_idx = {~col_ff, 3'(LAST_ROW - row_ff)};
   assign dot_on  = glyph_ff[bit_idx];

   // box geometry, all sums wrap at 16 bits
   assign c1 = c0_ff + scale_m1;
   assign r0 = y0_ff + row_offset;
   assign r1 = y0_ff + scale_m1 + row_offset;

   always_comb begin
      box_data[15:0]  = (c0_ff < c1) ? c0_ff : c1;
      box_data[31:16] = (c0_ff < c1) ? c1 : c0_ff;
      box_data[47:32] = (r0 < r1) ? r0 : r1;
      box_data[63:48] = (r0 < r1) ? r1 : r0;
      box_data[79:64] = dot_on ? fg_color : bg_color;
   end

   // dot walk and job load
   always_comb begin
      busy_in  = busy_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      glyph_in = glyph_ff;
      c0_in    = c0_ff;
      y0_in    = y0_ff;
      base_in  = base_ff;
      if (step) begin
         if (row_ff == LAST_ROW) begin
            row_in = '0;
            col_in = col_ff + 1'b1;
            c0_in  = c0_ff + scale16;
            y0_in  = base_ff;
         end else begin
            row_in = row_ff + 1'b1;
            y0_in  = y0_ff + scale16;
         end
         if (last_dot) begin
            busy_in = 1'b0;
         end
      end
      if (load_job) begin
         busy_in  = 1'b1;
         col_in   = '0;
         row_in   = '0;
         glyph_in = pop_data.glyph;
         c0_in    = pop_data.col;
         y0_in    = pop_data.row;
         base_in  = pop_data.row;
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      c0_ff    <= c0_in;
      y0_ff    <= y0_in;
      base_ff  <= base_in;
      if (step) begin
         out_data_ff <= box_data;
         out_last_ff <= last_dot;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hw/rtl/text_glyph_box_renderer.sv
// ---------------------------------------------------------------------------
// text_glyph_box_renderer: 4x7 bitmap font character generator
// Turns each character into 28 filled-box window commands at a text cursor.
// ---------------------------------------------------------------------------
//  port group  | dir | transfer carries
//  req_*       | in  | tdata: char_code, start_x, start_y; tuser: new_string
//  rsp_*       | out | tdata: col_start, col_end, row_start, row_end,
//              |     |       fill_color; tlast: last_box
//  csr_*       | in  | register write: index and data, no read-back
//
//  A character yields 28 boxes: the box sequencer emits one box per cycle.
//  The front end takes a character per cycle into a job queue of
//  QUEUE_DEPTH entries, so characters queue up while the sequencer works.
//  Stalls on rsp hold the output register and the sequencer; req keeps
//  flowing until the queue fills. Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
module text_glyph_box_renderer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // character stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,  // char_code, start_x, start_y
   input  logic                            req_tuser,  // new_string
   // box stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [79:0]                     rsp_tdata,  // col_start, col_end,
                                                       // row_start, row_end,
                                                       // fill_color
   output logic                            rsp_tlast,  // last_box
   // configuration writes
   input  logic                            csr_wen,
   input  logic [tgb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [15:0]                     csr_wdata
);
   import tgb_pkg::*;

   logic [15:0]   fg_color_ff;
   logic [15:0]   bg_color_ff;
   logic [7:0]    pixel_scale_ff;
   logic [15:0]   row_offset_ff;

   logic          push_valid;
   logic          push_ready;
   glyph_job_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   glyph_job_type pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff    <= FG_COLOR_RST;
         bg_color_ff    <= BG_COLOR_RST;
         pixel_scale_ff <= PIXEL_SCALE_RST;
         row_offset_ff  <= ROW_OFFSET_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_FG_COLOR:    fg_color_ff    <= csr_wdata;
            CSR_BG_COLOR:    bg_color_ff    <= csr_wdata;
            CSR_PIXEL_SCALE: pixel_scale_ff <= csr_wdata[7:0];
            CSR_ROW_OFFSET:  row_offset_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // character front end
   tgb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .pixel_scale (pixel_scale_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // job queue
   tgb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // box sequencer
   tgb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .fg_color    (fg_color_ff),
      .bg_color    (bg_color_ff),
      .pixel_scale (pixel_scale_ff),
      .row_offset  (row_offset_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
